### rtl/msts_pkg.sv
package msts_pkg;

  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned REPEAT_W    = 16;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned TIMER_IDX_W = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 3'd0,
    ACT_LOAD    = 3'd1,
    ACT_START   = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_SET_IVL = 3'd4,
    ACT_SET_CNT = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

### rtl/multi_soft_timer_scheduler.sv
// Set-up actions leave busy_o low, so the next beat may follow at once.
// A tick holds busy_o over its scan of timers_in_use entries (max NUM_TIMERS) and ST_DONE.
// One shared update unit visits one table entry per cycle through a registered memory read.
// Results are registered and leave in the cycle after the entry that completes them; the final one has last_o set.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// rst_ni clears the active and enable bits, the scan length and the sequencer at once.
module multi_soft_timer_scheduler #(
  parameter int unsigned NUM_TIMERS    = 16,
  parameter int unsigned INTERVAL_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [msts_pkg::ACTION_W-1:0]     action_i,
  input  logic [msts_pkg::TIMER_IDX_W-1:0]  timer_index_i,
  input  logic [INTERVAL_BITS-1:0]          interval_ticks_i,
  input  logic [msts_pkg::REPEAT_W-1:0]     occurrence_count_i,
  input  logic                              auto_start_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [msts_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                              result_valid_o,
  output logic                              fired_o,
  output logic [msts_pkg::TIMER_IDX_W-1:0]  fired_timer_o,
  output logic                              last_o
);

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned EXT_W = (IDX_W > msts_pkg::TIMER_IDX_W) ? IDX_W
                                                                  : msts_pkg::TIMER_IDX_W;

  msts_pkg::state_e state_q, state_d;

  logic [msts_pkg::CFG_W-1:0] tiu_q;
  logic [IDX_W-1:0]           cnt_q, cnt_d;
  logic [IDX_W-1:0]           scan_last_q, scan_last_d;
  logic                       pend_q, pend_d;
  logic [IDX_W-1:0]           pend_idx_q, pend_idx_d;
  logic [NUM_TIMERS-1:0]      active_q, active_d;
  logic [NUM_TIMERS-1:0]      enabled_q, enabled_d;

  logic                       out_valid_q, out_valid_d;
  logic                       out_fired_q, out_fired_d;
  logic [IDX_W-1:0]           out_idx_q, out_idx_d;
  logic                       out_last_q, out_last_d;

  logic [INTERVAL_BITS-1:0]      rem_mem [NUM_TIMERS];
  logic [INTERVAL_BITS-1:0]      rld_mem [NUM_TIMERS];
  logic [msts_pkg::REPEAT_W-1:0] rep_mem [NUM_TIMERS];
  logic [INTERVAL_BITS-1:0]      rd_rem_q, rd_rld_q;
  logic [msts_pkg::REPEAT_W-1:0] rd_rep_q;
  logic [IDX_W-1:0]              rd_addr;

  logic                          wr_rem_en, wr_rld_en, wr_rep_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [INTERVAL_BITS-1:0]      wr_rem_data;
  logic [msts_pkg::REPEAT_W-1:0] wr_rep_data;

  logic                       accept;
  logic                       idx_ok;
  logic [IDX_W-1:0]           setup_idx;
  logic [EXT_W-1:0]           idx_ext;
  logic [EXT_W-1:0]           out_idx_ext;
  logic [31:0]                scan_len;

  assign busy_o      = (state_q != msts_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  assign idx_ext   = EXT_W'(timer_index_i);
  assign setup_idx = idx_ext[IDX_W-1:0];
  assign idx_ok    = (32'(timer_index_i) < NUM_TIMERS);
  assign scan_len  = (32'(tiu_q) > NUM_TIMERS) ? NUM_TIMERS : 32'(tiu_q);

  // The entry after the one being updated is fetched while the update is written back.
  assign rd_addr = (state_q == msts_pkg::ST_SCAN) ? cnt_q + 1'b1 : '0;

  always_ff @(posedge clk_i) begin
    rd_rem_q <= rem_mem[rd_addr];
    rd_rld_q <= rld_mem[rd_addr];
    rd_rep_q <= rep_mem[rd_addr];
    if (wr_rem_en) begin
      rem_mem[wr_addr] <= wr_rem_data;
    end
    if (wr_rld_en) begin
      rld_mem[wr_addr] <= interval_ticks_i;
    end
    if (wr_rep_en) begin
      rep_mem[wr_addr] <= wr_rep_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msts_pkg::ST_IDLE;
      tiu_q       <= '0;
      cnt_q       <= '0;
      scan_last_q <= '0;
      pend_q      <= 1'b0;
      active_q    <= '0;
      enabled_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      scan_last_q <= scan_last_d;
      pend_q      <= pend_d;
      active_q    <= active_d;
      enabled_q   <= enabled_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tiu_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    out_fired_q <= out_fired_d;
    out_idx_q   <= out_idx_d;
    out_last_q  <= out_last_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    scan_last_d = scan_last_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    active_d    = active_q;
    enabled_d   = enabled_q;
    out_valid_d = 1'b0;
    out_fired_d = 1'b0;
    out_idx_d   = '0;
    out_last_d  = 1'b0;
    wr_rem_en   = 1'b0;
    wr_rld_en   = 1'b0;
    wr_rep_en   = 1'b0;
    wr_addr     = setup_idx;
    wr_rem_data = interval_ticks_i;
    wr_rep_data = occurrence_count_i;

    unique case (state_q)
      msts_pkg::ST_IDLE: begin
        if (accept) begin
          if (action_i == msts_pkg::ACT_TICK) begin
            cnt_d       = '0;
            pend_d      = 1'b0;
            scan_last_d = IDX_W'(scan_len - 32'd1);
            state_d     = (scan_len == 32'd0) ? msts_pkg::ST_DONE : msts_pkg::ST_SCAN;
          end else if (idx_ok) begin
            unique case (action_i)
              msts_pkg::ACT_LOAD: begin
                wr_rem_en            = 1'b1;
                wr_rld_en            = 1'b1;
                wr_rep_en            = 1'b1;
                active_d[setup_idx]  = 1'b1;
                enabled_d[setup_idx] = auto_start_i;
              end
              msts_pkg::ACT_START:   enabled_d[setup_idx] = 1'b1;
              msts_pkg::ACT_STOP:    enabled_d[setup_idx] = 1'b0;
              msts_pkg::ACT_SET_IVL: begin
                wr_rem_en = 1'b1;
                wr_rld_en = 1'b1;
              end
              msts_pkg::ACT_SET_CNT: wr_rep_en = 1'b1;
              default: ;
            endcase
          end
        end
      end

      msts_pkg::ST_SCAN: begin
        wr_addr     = cnt_q;
        wr_rep_data = rd_rep_q - 1'b1;
        if (active_q[cnt_q]) begin
          if (rd_rem_q == '0) begin
            wr_rem_en   = 1'b1;
            wr_rem_data = rd_rld_q;
            if (rd_rep_q != '0) begin
              wr_rep_en = 1'b1;
              if (rd_rep_q == msts_pkg::REPEAT_W'(1)) begin
                active_d[cnt_q] = 1'b0;
              end
            end
            // A fire is held back until the scan shows whether another follows it.
            if (pend_q) begin
              out_valid_d = 1'b1;
              out_fired_d = 1'b1;
              out_idx_d   = pend_idx_q;
            end
            pend_d     = 1'b1;
            pend_idx_d = cnt_q;
          end else if (enabled_q[cnt_q]) begin
            wr_rem_en   = 1'b1;
            wr_rem_data = rd_rem_q - 1'b1;
          end
        end
        if (cnt_q == scan_last_q) begin
          state_d = msts_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      msts_pkg::ST_DONE: begin
        out_valid_d = 1'b1;
        out_fired_d = pend_q;
        out_idx_d   = pend_q ? pend_idx_q : '0;
        out_last_d  = 1'b1;
        pend_d      = 1'b0;
        state_d     = msts_pkg::ST_IDLE;
      end

      default: state_d = msts_pkg::ST_IDLE;
    endcase
  end

  assign out_idx_ext    = EXT_W'(out_idx_q);
  assign result_valid_o = out_valid_q;
  assign fired_o        = out_fired_q;
  assign fired_timer_o  = out_idx_ext[msts_pkg::TIMER_IDX_W-1:0];
  assign last_o         = out_last_q;

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !fired_o) |-> last_o)
    else $error("empty tick result without last");

  a_done_emits_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msts_pkg::ST_DONE) |=> (result_valid_o && last_o && !busy_o))
    else $error("tick finished without a final result");

  a_last_only_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> $past(state_q == msts_pkg::ST_DONE))
    else $error("final result outside the end of a tick");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msts_pkg::ST_SCAN) |-> (cnt_q <= scan_last_q))
    else $error("scan index ran past the scan length");
`endif

endmodule
